// File: hdl/bcsl_pkg.sv
// Shared types and constants for the bounded byte sequence list.
// Used by bcsl_ram, bounded_char_sequence_list, bcsl_checker and tb; no other dependencies.
package bcsl_pkg;

  // Store depth; slot arithmetic wraps modulo DEPTH, so it stays a power of two.
  localparam int DEPTH  = 64;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = AW + 1;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE_AT  = 3'd4,
    OP_READ_AT    = 3'd5,
    OP_CONTAINS   = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_RDWAIT = 6'b000100,
    S_SCAN   = 6'b001000,
    S_SHIFT  = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

endpackage

// File: hdl/bcsl_ram.sv
// Element store: DEPTH x 8 bit memory, one write port, one registered read port.
// Depends on bcsl_pkg for depth and widths.
module bcsl_ram
  import bcsl_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bounded_char_sequence_list.sv
// Bounded byte sequence list: push/pop at both ends, indexed read and remove,
// membership test and clear, over a circular store in bcsl_ram (uses bcsl_pkg).
// Push, pop and clear pass from the exec state straight to the response state; read-at
// also waits out the store read; contains scans the held elements, remove-at shifts those behind the position.
// One command at a time; the scan and shift loops go one store entry per cycle
// through the single memory port pair.
// Reset (rst, synchronous) empties the list; store contents need no clearing.
module bounded_char_sequence_list
  import bcsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: [2:0] opcode, [8:3] position, [16:9] byte_value, [23:17] zero
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: [1:0] status, [9:2] read_byte, [10] found, [17:11] element_count,
  //          [23:18] zero
  output logic [23:0] m_tdata
);

  state_t             state;
  op_t                op;
  logic [POS_W-1:0]   pos;
  logic [BYTE_W-1:0]  val;
  logic [AW-1:0]      fp;        // slot of the front element
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;       // loop index, counted from the front
  logic               pend;      // a read issued last cycle returns now
  logic [AW-1:0]      wr_slot;   // destination of the returning shift read
  status_t            status;
  logic [BYTE_W-1:0]  rd_byte;
  logic               found;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic [AW-1:0]      rd_off;
  logic [AW-1:0]      ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  logic               full;
  logic               empty;
  logic               pos_bad;
  logic               scan_issue;
  logic               shift_issue;
  logic [CNT_W-1:0]   idx_inc;
  logic               in_xact;
  logic               out_load;

  assign in_xact  = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_RESP) && (!m_tvalid || m_tready);

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pos_bad = ({1'b0, pos} >= count);
  assign idx_inc = idx + 1'b1;

  // Contains keeps fetching until every held element has been read.
  assign scan_issue  = (idx < count);
  // Remove-at pulls element idx+1 down into slot idx while one is left behind it.
  assign shift_issue = (idx_inc < count);

  // Shared slot adder: front pointer plus an offset from the front.
  assign ram_raddr = fp + rd_off;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fp;
    ram_wdata = val;
    rd_off    = idx[AW-1:0];
    unique case (state)
      S_EXEC: begin
        rd_off = pos[AW-1:0];
        if (op == OP_PUSH_FRONT) begin
          ram_we    = !full;
          ram_waddr = fp - 1'b1;
        end else if (op == OP_PUSH_BACK) begin
          ram_we    = !full;
          ram_waddr = fp + count[AW-1:0];
        end
      end
      S_SHIFT: begin
        rd_off    = idx_inc[AW-1:0];
        ram_we    = pend;
        ram_waddr = wr_slot;
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  bcsl_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fp    <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xact) begin
            // Capture the command and clear the result fields.
            op      <= op_t'(s_tdata[2:0]);
            pos     <= s_tdata[8:3];
            val     <= s_tdata[16:9];
            status  <= ST_OK;
            rd_byte <= '0;
            found   <= 1'b0;
            idx     <= '0;
            pend    <= 1'b0;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_RESP;
          unique case (op)
            OP_PUSH_FRONT: begin
              if (full) begin
                status <= ST_FULL;
              end else begin
                fp    <= fp - 1'b1;
                count <= count + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                status <= ST_FULL;
              end else begin
                count <= count + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                status <= ST_RANGE;
              end else begin
                fp    <= fp + 1'b1;
                count <= count - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                status <= ST_RANGE;
              end else begin
                count <= count - 1'b1;
              end
            end
            OP_REMOVE_AT: begin
              if (pos_bad) begin
                status <= ST_RANGE;
              end else begin
                idx   <= {1'b0, pos};
                state <= S_SHIFT;
              end
            end
            OP_READ_AT: begin
              // Read of slot fp+pos is already on its way out of the store.
              if (pos_bad) begin
                status <= ST_RANGE;
              end else begin
                state <= S_RDWAIT;
              end
            end
            OP_CONTAINS: begin
              state <= S_SCAN;
            end
            OP_CLEAR: begin
              fp    <= '0;
              count <= '0;
            end
            default: begin
            end
          endcase
        end
        S_RDWAIT: begin
          rd_byte <= ram_rdata;
          state   <= S_RESP;
        end
        S_SCAN: begin
          pend <= scan_issue;
          if (scan_issue) begin
            idx <= idx_inc;
          end
          if (pend && (ram_rdata == val)) begin
            found <= 1'b1;
            pend  <= 1'b0;
            state <= S_RESP;
          end else if (!scan_issue && !pend) begin
            state <= S_RESP;
          end
        end
        S_SHIFT: begin
          pend <= shift_issue;
          if (shift_issue) begin
            wr_slot <= fp + idx[AW-1:0];
            idx     <= idx_inc;
          end else if (!pend) begin
            // Last move has landed; drop the tail element.
            count <= count - 1'b1;
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: hold the result until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, count, found, rd_byte, status};
    end
  end

endmodule

// File: sim/bcsl_checker.sv
// Scoreboard for the bounded byte sequence list: watches both stream channels,
// predicts each result from the accepted commands and compares. Uses bcsl_pkg.
`timescale 1ns / 100ps

module bcsl_checker
  import bcsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int unsigned REPORT_CAP = 200;

  typedef struct packed {
    logic [1:0]        status;
    logic [BYTE_W-1:0] read_byte;
    logic              found;
    logic [CNT_W-1:0]  element_count;
  } reply_t;

  // Shadow of the list: circular store, front slot and element count.
  logic [BYTE_W-1:0] list_mem [DEPTH];
  logic [AW-1:0]     head;
  logic [CNT_W-1:0]  held;
  reply_t            expected_replies [$];

  function automatic logic [AW-1:0] slot(input int offset);
    return head + offset[AW-1:0];
  endfunction

  function automatic reply_t apply_command(input op_t op, input int pos,
                                           input logic [BYTE_W-1:0] val);
    reply_t r;
    int     i;
    r = '0;
    case (op)
      OP_PUSH_FRONT: begin
        if (int'(held) >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head = head - 1'b1;
          list_mem[head] = val;
          held = held + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (int'(held) >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[slot(int'(held))] = val;
          held = held + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (held == 0) begin
          r.status = ST_RANGE;
        end else begin
          head = head + 1'b1;
          held = held - 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (held == 0) r.status = ST_RANGE;
        else held = held - 1'b1;
      end
      OP_REMOVE_AT: begin
        if (pos >= int'(held)) begin
          r.status = ST_RANGE;
        end else begin
          // close the gap: later elements move one place toward the front
          for (i = pos; i + 1 < int'(held); i++)
            list_mem[slot(i)] = list_mem[slot(i + 1)];
          held = held - 1'b1;
        end
      end
      OP_READ_AT: begin
        if (pos >= int'(held)) r.status = ST_RANGE;
        else r.read_byte = list_mem[slot(pos)];
      end
      OP_CONTAINS: begin
        for (i = 0; i < int'(held); i++) begin
          if (list_mem[slot(i)] == val) begin
            r.found = 1'b1;
            break;
          end
        end
      end
      default: begin
        held = '0;
        head = '0;
      end
    endcase
    r.element_count = held;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    reply_t got;
    reply_t want;
    if (rst) begin
      head = '0;
      held = '0;
      expected_replies.delete();
      mismatches = 0;
    end else begin
      // results first: a result never answers a command accepted at the same edge
      if (m_tvalid && m_tready) begin
        got.status        = m_tdata[1:0];
        got.read_byte     = m_tdata[9:2];
        got.found         = m_tdata[10];
        got.element_count = m_tdata[17:11];
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: result with none expected: status %0d read %02h found %0b count %0d",
                     $time, got.status, got.read_byte, got.found, got.element_count);
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status || got.read_byte !== want.read_byte ||
              got.found !== want.found || got.element_count !== want.element_count) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
              $display({"%0t: mismatch: expected status %0d read %02h found %0b count %0d,",
                        " got status %0d read %02h found %0b count %0d"}, $time,
                       want.status, want.read_byte, want.found, want.element_count,
                       got.status, got.read_byte, got.found, got.element_count);
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_replies.push_back(apply_command(op_t'(s_tdata[2:0]), int'(s_tdata[8:3]),
                                                 s_tdata[16:9]));
    end
    outstanding = expected_replies.size();
  end

endmodule

// File: sim/tb.sv
// Testbench top for bounded_char_sequence_list: clock, reset, command stimulus
// and verdict. Needs bcsl_pkg, the block itself and bcsl_checker.
`timescale 1ns / 100ps

module tb;
  import bcsl_pkg::*;

  // Limit for the whole run of about 1300 commands, set above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int          TOTAL_ITEMS  = 1200;
  localparam int          QUIET_TAIL   = 150;  // final commands with no idling at all
  localparam int          DRAIN_CYCLES = 80;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  // Idling switches, changed between stimulus patterns.
  bit sender_idles   = 1'b0;
  bit receiver_idles = 1'b0;

  // Number of elements the list should hold; only used to aim positions and to
  // know when a fill has reached the top. The checker does the real prediction.
  int level = 0;
  int sent  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_char_sequence_list u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  bcsl_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Present one command and hold it until its transaction completes. Called at a
  // falling edge; returns at the falling edge after acceptance with tvalid still
  // high, so back-to-back commands keep tvalid up between them unless the sender idles.
  task automatic send_command(input op_t op, input int pos, input int val);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, val[7:0], pos[5:0], op};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (level < DEPTH) level++;
      OP_POP_FRONT, OP_POP_BACK:   if (level > 0) level--;
      OP_REMOVE_AT:                if (pos < level) level--;
      OP_CLEAR:                    level = 0;
      default: ;
    endcase
    sent++;
  endtask

  // Drop tvalid and hold off until every result has come back.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  // Mostly a held index, now and then the first index past the end or anything.
  function automatic int aim_position();
    if (level > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, level - 1);
    if (level < DEPTH && $urandom_range(0, 1) == 0) return level;
    return $urandom_range(0, 63);
  endfunction

  // Half the bytes from a tiny alphabet so that membership tests often hit.
  function automatic int pick_byte();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 7);
    return $urandom_range(0, 255);
  endfunction

  function automatic op_t mixed_op();
    int r;
    r = $urandom_range(0, 31);
    if (r < 6)  return OP_PUSH_FRONT;
    if (r < 12) return OP_PUSH_BACK;
    if (r < 15) return OP_POP_FRONT;
    if (r < 18) return OP_POP_BACK;
    if (r < 22) return OP_REMOVE_AT;
    if (r < 26) return OP_READ_AT;
    if (r < 31) return OP_CONTAINS;
    return OP_CLEAR;
  endfunction

  function automatic op_t indexed_op();
    case ($urandom_range(0, 2))
      0:       return OP_READ_AT;
      1:       return OP_REMOVE_AT;
      default: return OP_CONTAINS;
    endcase
  endfunction

  // Fill to the top from both ends, knock on the full store, work the indexes
  // of a full (and wrapped) list, then pop it empty and pop once more.
  task automatic fill_then_drain();
    while (level < DEPTH)
      send_command($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                   $urandom_range(0, 63), $urandom_range(0, 255));
    repeat ($urandom_range(1, 3))
      send_command($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                   $urandom_range(0, 63), $urandom_range(0, 255));
    repeat ($urandom_range(4, 12))
      send_command(indexed_op(), $urandom_range(0, 63), $urandom_range(0, 255));
    while (level > 0)
      send_command($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                   $urandom_range(0, 63), $urandom_range(0, 255));
    send_command($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                 $urandom_range(0, 63), $urandom_range(0, 255));
  endtask

  // Receiver side: stall in bursts while enabled, otherwise take every result.
  initial begin
    forever begin
      @(negedge clk);
      if (receiver_idles && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty list: pops and indexed access report range, contains finds nothing.
    send_command(OP_POP_FRONT, 0, 0);
    send_command(OP_POP_BACK, 0, 0);
    send_command(OP_READ_AT, 0, 0);
    send_command(OP_REMOVE_AT, 0, 0);
    send_command(OP_CONTAINS, 0, 8'h00);
    // Build A5 00 FF 5A from both ends, wrapping the front below slot zero.
    send_command(OP_PUSH_FRONT, 63, 8'h00);
    send_command(OP_PUSH_BACK, 0, 8'hFF);
    send_command(OP_PUSH_FRONT, 0, 8'hA5);
    send_command(OP_PUSH_BACK, 63, 8'h5A);
    send_command(OP_READ_AT, 0, 0);
    send_command(OP_READ_AT, 3, 0);
    send_command(OP_READ_AT, 4, 0);         // first index past the end
    send_command(OP_READ_AT, 63, 8'hFF);
    send_command(OP_CONTAINS, 0, 8'hFF);
    send_command(OP_CONTAINS, 0, 8'h12);
    send_command(OP_REMOVE_AT, 1, 0);       // middle: later elements close up
    send_command(OP_READ_AT, 1, 0);
    send_command(OP_REMOVE_AT, 2, 0);       // last element
    send_command(OP_REMOVE_AT, 63, 0);
    send_command(OP_POP_FRONT, 0, 0);
    send_command(OP_POP_BACK, 0, 0);
    send_command(OP_PUSH_BACK, 0, 8'h3C);
    send_command(OP_CLEAR, 0, 0);
    send_command(OP_CONTAINS, 0, 8'h3C);

    // Sender waits out every outstanding result at least once.
    hold_until_drained();

    while (sent < TOTAL_ITEMS) begin
      if (sent >= TOTAL_ITEMS - QUIET_TAIL) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end else begin
        sender_idles   = $urandom_range(0, 3) != 0;
        receiver_idles = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 7) == 0) hold_until_drained();
      end
      case ($urandom_range(0, 9))
        0, 1: fill_then_drain();
        9:    send_command(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 255));
        default: begin
          repeat (20) send_command(mixed_op(), aim_position(), pick_byte());
        end
      endcase
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
